@@ rtl/ppi_pkg.sv @@
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types and constants for the three-port parallel interface
// in basic mode.
// ----------------------------------------------------------------------------
package ppi_pkg;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] port;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] pins_a;
      logic [7:0] pins_b;
      logic [7:0] pins_c;
   } rsp_type;

   // operation codes
   localparam logic [1:0] OP_READ    = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_PRESENT = 2'd2;

   // port selects
   localparam logic [1:0] SEL_A    = 2'd0;
   localparam logic [1:0] SEL_B    = 2'd1;
   localparam logic [1:0] SEL_C    = 2'd2;
   localparam logic [1:0] SEL_CTRL = 2'd3;

   // control word
   localparam logic [7:0] CTRL_RESET   = 8'h9B;
   localparam int         CW_MODE_SET  = 7;
   localparam int         CW_A_IN      = 4;
   localparam int         CW_C_HI_IN   = 3;
   localparam int         CW_B_IN      = 1;
   localparam int         CW_C_LO_IN   = 0;

   localparam logic [7:0] LATCH_RESET  = 8'h00;
   localparam logic [7:0] LEVEL_RESET  = 8'hFF;
   localparam logic [7:0] NIB_HI       = 8'hF0;
   localparam logic [7:0] NIB_LO       = 8'h0F;

endpackage

@@ rtl/ppi_core.sv @@
// ----------------------------------------------------------------------------
// ppi_core
// Port state (control word, output latches, pin levels) and the
// combinational read / write / pin-update logic applied to one request.
// ----------------------------------------------------------------------------
module ppi_core
   import ppi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    enable,
   input  req_type item,
   output rsp_type result
);

   logic [7:0] ctrl_ff,  ctrl_in;
   logic [7:0] latch_a_ff, latch_a_in;
   logic [7:0] latch_b_ff, latch_b_in;
   logic [7:0] latch_c_ff, latch_c_in;
   logic [7:0] level_a_ff, level_a_in;
   logic [7:0] level_b_ff, level_b_in;
   logic [7:0] level_c_ff, level_c_in;
   logic [7:0] bit_mask;
   logic [7:0] rd_c_lo;
   logic [7:0] rd_c_hi;
   logic [7:0] rd_value;

   assign bit_mask = 8'd1 << item.data[3:1];

   // read data from the state before this request
   always_comb begin
      rd_c_lo = ctrl_ff[CW_C_LO_IN] ? level_c_ff : latch_c_ff;
      rd_c_hi = ctrl_ff[CW_C_HI_IN] ? level_c_ff : latch_c_ff;
      case (item.port)
         SEL_A:   rd_value = ctrl_ff[CW_A_IN] ? level_a_ff : latch_a_ff;
         SEL_B:   rd_value = ctrl_ff[CW_B_IN] ? level_b_ff : latch_b_ff;
         SEL_C:   rd_value = (rd_c_hi & NIB_HI) | (rd_c_lo & NIB_LO);
         default: rd_value = ctrl_ff;
      endcase
   end

   always_comb begin
      ctrl_in    = ctrl_ff;
      latch_a_in = latch_a_ff;
      latch_b_in = latch_b_ff;
      latch_c_in = latch_c_ff;
      level_a_in = level_a_ff;
      level_b_in = level_b_ff;
      level_c_in = level_c_ff;
      case (item.op)
         OP_WRITE: begin
            case (item.port)
               SEL_A: latch_a_in = item.data;
               SEL_B: latch_b_in = item.data;
               SEL_C: latch_c_in = item.data;
               default: begin
                  if (item.data[CW_MODE_SET]) begin
                     ctrl_in    = item.data;
                     latch_a_in = LATCH_RESET;
                     latch_b_in = LATCH_RESET;
                     latch_c_in = LATCH_RESET;
                  end else if (item.data[0]) begin
                     latch_c_in = latch_c_ff | bit_mask;
                  end else begin
                     latch_c_in = latch_c_ff & ~bit_mask;
                  end
               end
            endcase
         end
         OP_PRESENT: begin
            case (item.port)
               SEL_A:   level_a_in = item.data;
               SEL_B:   level_b_in = item.data;
               SEL_C:   level_c_in = item.data;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // pins reflect the state after this request
   always_comb begin
      result.read_data = (item.op == OP_READ) ? rd_value : 8'h00;
      result.pins_a    = ctrl_in[CW_A_IN] ? LEVEL_RESET : latch_a_in;
      result.pins_b    = ctrl_in[CW_B_IN] ? LEVEL_RESET : latch_b_in;
      result.pins_c    = (ctrl_in[CW_C_HI_IN] ? NIB_HI : (latch_c_in & NIB_HI))
                       | (ctrl_in[CW_C_LO_IN] ? NIB_LO : (latch_c_in & NIB_LO));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff    <= CTRL_RESET;
         latch_a_ff <= LATCH_RESET;
         latch_b_ff <= LATCH_RESET;
         latch_c_ff <= LATCH_RESET;
         level_a_ff <= LEVEL_RESET;
         level_b_ff <= LEVEL_RESET;
         level_c_ff <= LEVEL_RESET;
      end else if (enable) begin
         ctrl_ff    <= ctrl_in;
         latch_a_ff <= latch_a_in;
         latch_b_ff <= latch_b_in;
         latch_c_ff <= latch_c_in;
         level_a_ff <= level_a_in;
         level_b_ff <= level_b_in;
         level_c_ff <= level_c_in;
      end
   end

endmodule

@@ rtl/parallel_port_interface_mode0.sv @@
// ----------------------------------------------------------------------------
// parallel_port_interface_mode0
// Three-port parallel interface, basic mode: bus reads and writes, control
// mode-set and port C bit set/reset, and external pin level updates.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one request (op, port, data) per handshake; rsp
//   channel returns exactly one result per request, in order, with the
//   read data and the driven levels of ports A, B and C after the request.
//   A request is taken when req_valid is high and req_stall is low; a
//   result is taken when rsp_valid is high and rsp_stall is low.
// Pipeline: an accepted request sits in the input register; its result is
//   computed from it, captured in the result register and presented on rsp.
// Throughput: one request per clock while rsp is not stalled. The whole port
//   update is combinational logic between the input and result registers.
// Reset: control word returns to 9B (all ports input), output latches clear,
//   pin levels read as all ones; both registers empty.
// Stall: while rsp is stalled with a result held, the input register keeps
//   its request and raises req_stall only if it is itself occupied.
// ----------------------------------------------------------------------------
module parallel_port_interface_mode0
   import ppi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   req_type s1_ff, s1_in;
   logic    s1_valid_ff, s1_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type core_result;
   logic    out_ready;
   logic    advance;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;

   ppi_core u_core (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .item   (s1_ff),
      .result (core_result)
   );

   always_comb begin
      s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
      s1_in        = (req_valid && !req_stall) ? req_payload : s1_ff;
      rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;
      rsp_in       = advance ? core_result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !s1_valid_ff))
      else $error("pipeline not empty after reset");

   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_ready) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("held request lost while output stalled");

   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed request produced no result");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_ff))
      else $error("stalled result overwritten");

endmodule
